// ===== design/ptt_pkg.sv =====
package ptt_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_DESTROY = 2'd2;

    localparam logic [1:0] KIND_SET     = 2'd0;
    localparam logic [1:0] KIND_DESTROY = 2'd1;
    localparam logic [1:0] KIND_FIRE    = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CW     = $clog2(MAX_RESULTS + 1);

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] end_time;
        logic [31:0] interval;
        logic [31:0] remaining;
        logic [15:0] code;
        logic [31:0] destination;
    } slot_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SET_SCAN,
        S_SET_REPLY,
        S_DES_SCAN,
        S_DES_REPLY,
        S_TICK_SCAN,
        S_TICK_EVAL,
        S_FLUSH
    } ptt_state_t;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic cand_load;
        logic cand_step;
        logic set_reply;
        logic des_reply;
        logic tick_commit;
        logic flush;
    } ptt_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       code_zero;
        logic       any_free;
        logic       scan_done;
        logic       scan_hit;
        logic       best_found;
        logic       fire_needed;
        logic       hold_valid;
        logic       out_free;
    } ptt_sts_t;

    function automatic logic [31:0] next_id(input logic [31:0] x);
        logic [31:0] n;
        n = x + 32'd1;
        return (n == 32'd0) ? 32'd1 : n;
    endfunction

endpackage

// ===== design/ptt_ram.sv =====
module ptt_ram #(
    parameter int WIDTH = 176,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ptt_datapath.sv =====
module ptt_datapath
    import ptt_pkg::*;
#(
    parameter int TIMERS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptt_cmd_t              cmd,
    output ptt_sts_t              sts,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [1:0]            in_op,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [1:0]            out_kind,
    output logic                  out_last
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    localparam int EW = $bits(slot_entry_t);

    logic [1:0]         op_reg;
    logic [31:0]        now_reg;
    logic [31:0]        ivl_reg;
    logic signed [31:0] rep_reg;
    logic [15:0]        code_reg;
    logic [31:0]        dest_reg;
    logic [31:0]        target_reg;

    logic [TIMERS-1:0]  slot_valid_reg;
    logic [31:0]        id_counter_reg;
    logic [31:0]        cand_reg;
    logic [31:0]        prev_reg;
    logic               have_prev_reg;
    logic [FIRE_CW-1:0] fire_cnt_reg;

    logic [CW-1:0]      addr_cnt_reg;
    logic               rd_vld_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               match_reg;
    logic [IW-1:0]      match_idx_reg;
    logic               best_found_reg;
    logic [IW-1:0]      best_idx_reg;
    slot_entry_t        best_reg;

    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic [31:0]        out_id_reg;
    logic [1:0]         out_status_reg;
    logic [15:0]        out_code_reg;
    logic [31:0]        out_dest_reg;
    logic               out_last_reg;
    logic               hold_valid_reg;
    logic [31:0]        hold_id_reg;
    logic [15:0]        hold_code_reg;
    logic [31:0]        hold_dest_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    slot_entry_t        ram_wdata;
    logic [EW-1:0]      ram_rdata;
    slot_entry_t        rd_entry;
    slot_entry_t        new_entry;
    slot_entry_t        upd_entry;

    logic [IW-1:0]      free_idx;
    logic               any_free;
    logic               code_zero;
    logic [31:0]        key;
    logic               cur_valid;
    logic               cur_hit;
    logic               cur_cand;
    logic               fire_needed;
    logic               out_free;
    logic               set_ok;
    logic               push_out;
    logic               out_load;

    ptt_ram #(
        .WIDTH(EW),
        .DEPTH(TIMERS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(addr_cnt_reg[IW-1:0]),
        .rdata(ram_rdata)
    );

    assign rd_entry = slot_entry_t'(ram_rdata);

    always_comb
    begin
        free_idx = '0;
        for (int i = TIMERS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign any_free  = !(&slot_valid_reg);
    assign code_zero = (code_reg == 16'd0);
    assign set_ok    = !code_zero && any_free;
    assign key       = (op_reg == OP_SET) ? cand_reg : target_reg;
    assign cur_valid = rd_vld_reg && slot_valid_reg[rd_idx_reg];
    assign cur_hit   = cur_valid && (rd_entry.id == key);
    assign cur_cand  = cur_valid && (!have_prev_reg || (rd_entry.id > prev_reg))
                       && (!best_found_reg || (rd_entry.id < best_reg.id));

    assign fire_needed = (best_reg.remaining != 32'd0) && (now_reg >= best_reg.end_time)
                         && (fire_cnt_reg < FIRE_CW'(MAX_RESULTS));
    assign out_free    = !out_valid_reg || out_ready;
    assign push_out    = cmd.tick_commit && fire_needed && hold_valid_reg;
    assign out_load    = cmd.set_reply || cmd.des_reply || cmd.flush || push_out;

    always_comb
    begin
        new_entry.id          = cand_reg;
        new_entry.end_time    = now_reg + ivl_reg;
        new_entry.interval    = ivl_reg;
        new_entry.remaining   = $unsigned(rep_reg);
        new_entry.code        = code_reg;
        new_entry.destination = dest_reg;

        upd_entry          = best_reg;
        upd_entry.end_time = best_reg.end_time + best_reg.interval;
        if (!best_reg.remaining[31])
        begin
            upd_entry.remaining = best_reg.remaining - 32'd1;
        end

        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata = new_entry;
        if (cmd.set_reply && set_ok)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.tick_commit && fire_needed)
        begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = upd_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            id_counter_reg <= '0;
            have_prev_reg  <= 1'b0;
            fire_cnt_reg   <= '0;
            addr_cnt_reg   <= CW'(TIMERS);
            rd_vld_reg     <= 1'b0;
            match_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                have_prev_reg <= 1'b0;
                fire_cnt_reg  <= '0;
            end

            if (cmd.scan_start)
            begin
                addr_cnt_reg   <= '0;
                rd_vld_reg     <= 1'b0;
                match_reg      <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (addr_cnt_reg < CW'(TIMERS))
                begin
                    addr_cnt_reg <= addr_cnt_reg + CW'(1);
                    rd_vld_reg   <= 1'b1;
                end
                else
                begin
                    rd_vld_reg <= 1'b0;
                end
                if (cur_hit)
                begin
                    match_reg <= 1'b1;
                end
                if (cur_cand)
                begin
                    best_found_reg <= 1'b1;
                end
            end

            if (cmd.set_reply && set_ok)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
                id_counter_reg           <= cand_reg;
            end
            else if (cmd.des_reply && match_reg)
            begin
                slot_valid_reg[match_idx_reg] <= 1'b0;
            end
            else if (cmd.tick_commit)
            begin
                have_prev_reg <= 1'b1;
                if (best_reg.remaining == 32'd0)
                begin
                    slot_valid_reg[best_idx_reg] <= 1'b0;
                end
                else if (fire_needed)
                begin
                    fire_cnt_reg <= fire_cnt_reg + FIRE_CW'(1);
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.tick_commit && fire_needed)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= in_op;
            now_reg    <= in_data[31:0];
            ivl_reg    <= in_data[63:32];
            rep_reg    <= $signed(in_data[95:64]);
            code_reg   <= in_data[111:96];
            dest_reg   <= in_data[143:112];
            target_reg <= in_data[175:144];
        end

        if (cmd.cand_load)
        begin
            cand_reg <= next_id(id_counter_reg);
        end
        else if (cmd.cand_step)
        begin
            cand_reg <= next_id(cand_reg);
        end

        if (!cmd.scan_start && (addr_cnt_reg < CW'(TIMERS)))
        begin
            rd_idx_reg <= addr_cnt_reg[IW-1:0];
        end
        if (cur_hit)
        begin
            match_idx_reg <= rd_idx_reg;
        end
        if (cur_cand)
        begin
            best_idx_reg <= rd_idx_reg;
            best_reg     <= rd_entry;
        end

        if (cmd.tick_commit)
        begin
            prev_reg <= best_reg.id;
        end

        if (cmd.set_reply)
        begin
            out_kind_reg <= KIND_SET;
            out_code_reg <= 16'd0;
            out_dest_reg <= 32'd0;
            out_last_reg <= 1'b1;
            if (code_zero)
            begin
                out_id_reg     <= 32'd0;
                out_status_reg <= STAT_REJECT;
            end
            else if (!any_free)
            begin
                out_id_reg     <= 32'd0;
                out_status_reg <= STAT_FULL;
            end
            else
            begin
                out_id_reg     <= cand_reg;
                out_status_reg <= STAT_OK;
            end
        end
        else if (cmd.des_reply)
        begin
            out_kind_reg   <= KIND_DESTROY;
            out_id_reg     <= target_reg;
            out_status_reg <= match_reg ? STAT_OK : STAT_REJECT;
            out_code_reg   <= 16'd0;
            out_dest_reg   <= 32'd0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.flush || push_out)
        begin
            out_kind_reg   <= KIND_FIRE;
            out_id_reg     <= hold_id_reg;
            out_status_reg <= STAT_OK;
            out_code_reg   <= hold_code_reg;
            out_dest_reg   <= hold_dest_reg;
            out_last_reg   <= cmd.flush;
        end

        if (cmd.tick_commit && fire_needed)
        begin
            hold_id_reg   <= best_reg.id;
            hold_code_reg <= best_reg.code;
            hold_dest_reg <= best_reg.destination;
        end
    end

    always_comb
    begin
        sts.op          = op_reg;
        sts.code_zero   = code_zero;
        sts.any_free    = any_free;
        sts.scan_done   = rd_vld_reg && (rd_idx_reg == IW'(TIMERS - 1));
        sts.scan_hit    = match_reg || cur_hit;
        sts.best_found  = best_found_reg;
        sts.fire_needed = fire_needed;
        sts.hold_valid  = hold_valid_reg;
        sts.out_free    = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {6'd0, out_dest_reg, out_code_reg, out_status_reg, out_id_reg};
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== design/ptt_ctrl.sv =====
module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ptt_sts_t sts,
    output ptt_cmd_t cmd
);

    ptt_state_t state_reg;
    ptt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_TICK:    state_next = S_TICK_SCAN;
                    OP_SET:     state_next = (sts.code_zero || !sts.any_free) ?
                                             S_SET_REPLY : S_SET_SCAN;
                    OP_DESTROY: state_next = S_DES_SCAN;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_SET_SCAN:
            begin
                if (sts.scan_done && !sts.scan_hit)
                begin
                    state_next = S_SET_REPLY;
                end
            end
            S_SET_REPLY:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DES_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_DES_REPLY;
                end
            end
            S_DES_REPLY:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_TICK_EVAL;
                end
            end
            S_TICK_EVAL:
            begin
                if (!sts.best_found)
                begin
                    state_next = S_FLUSH;
                end
                else if (!(sts.fire_needed && sts.hold_valid && !sts.out_free))
                begin
                    state_next = S_TICK_SCAN;
                end
            end
            S_FLUSH:
            begin
                if (!sts.hold_valid || sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_TICK:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    OP_SET:
                    begin
                        cmd.cand_load  = !sts.code_zero && sts.any_free;
                        cmd.scan_start = !sts.code_zero && sts.any_free;
                    end
                    OP_DESTROY:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    default:
                    begin
                        cmd.scan_start = 1'b0;
                    end
                endcase
            end
            S_SET_SCAN:
            begin
                cmd.cand_step  = sts.scan_done && sts.scan_hit;
                cmd.scan_start = sts.scan_done && sts.scan_hit;
            end
            S_SET_REPLY:
            begin
                cmd.set_reply = sts.out_free;
            end
            S_DES_REPLY:
            begin
                cmd.des_reply = sts.out_free;
            end
            S_TICK_EVAL:
            begin
                if (sts.best_found && !(sts.fire_needed && sts.hold_valid && !sts.out_free))
                begin
                    cmd.tick_commit = 1'b1;
                    cmd.scan_start  = 1'b1;
                end
            end
            S_FLUSH:
            begin
                cmd.flush = sts.hold_valid && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/periodic_timer_table_top.sv =====
// Periodic timer table: up to TIMERS timers with repeat counts.
// Input channel s_axis_*: one item is a tick, set or destroy operation
// (tuser selects it). Output channel m_axis_*: set and destroy each give one
// reply; a tick gives one fire item per due timer (at most 16), in ascending
// id order, and none when nothing is due. tlast marks the final item of an
// operation.
// Every operation searches the table by one slot per cycle through the
// single read port of the slot RAM. A destroy makes one pass. A set is
// answered without a pass when rejected or full; else it makes one pass
// per candidate id, moving to the next id while the candidate is live.
// A tick makes one pass per live timer, in ascending id order, and a last
// pass that finds no timer left.
// The next item is taken as soon as the previous operation is finished,
// even while its last result waits in the output register.
// Reset frees all timers and clears the id counter; no clearing pass.
// When the receiver stalls, results wait in the output register and one
// hold register, and the table scan pauses until there is room.
module periodic_timer_table_top
    import ptt_pkg::*;
#(
    parameter int TIMERS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_seconds, interval_seconds, repeat_count, message_code, destination, target_id
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_id, status, fired_code, fired_destination, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    ptt_cmd_t cmd;
    ptt_sts_t sts;

    ptt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptt_datapath #(
        .TIMERS(TIMERS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (s_axis_tdata),
        .in_op    (s_axis_tuser),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata),
        .out_kind (m_axis_tuser),
        .out_last (m_axis_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sts.hold_valid)
        else $error("fire item still held while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_commit && sts.fire_needed && sts.hold_valid) |-> sts.out_free)
        else $error("fire item pushed into a busy output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.set_reply || cmd.des_reply) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("reply not presented as final item");

endmodule
